@@ hdl/tpr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the postorder relabel unit: codes, widths, state type and
// the request and result structs. No dependencies.
package tpr_pkg;

    // Default capacity in nodes.
    localparam int MAX_NODES_DEF = 1024;

    // Saturation limit of the child pointer prefix sum.
    localparam logic [10:0] PTR_MAX = 11'h7FF;

    // Request codes.
    localparam logic [1:0] REQ_LOAD_NODE  = 2'd0;
    localparam logic [1:0] REQ_LOAD_CHILD = 2'd1;
    localparam logic [1:0] REQ_COMPUTE    = 2'd2;
    localparam logic [1:0] REQ_READ       = 2'd3;

    // Output table codes.
    localparam logic [1:0] TBL_PARENT  = 2'd0;
    localparam logic [1:0] TBL_POINTER = 2'd1;
    localparam logic [1:0] TBL_CHILD   = 2'd2;

    // Result kinds.
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_CLR,
        ST_P2A,
        ST_P2B,
        ST_P2C,
        ST_SUMR,
        ST_SUMW,
        ST_P3A,
        ST_P3B,
        ST_P3C,
        ST_LA,
        ST_LB,
        ST_LC
    } t_state;

    // One input item as seen by the core.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] entry_index;
        logic [10:0] parent_node;
        logic [9:0]  postorder_position;
        logic [10:0] child_pointer;
        logic [9:0]  child_node;
        logic [1:0]  read_table;
    } t_req;

    // One result item pushed by the core.
    typedef struct packed {
        logic        valid;
        logic        out_kind;
        logic [10:0] out_value;
    } t_res;

endpackage

@@ hdl/tpr_if.sv @@
`timescale 1ns / 1ps
// Handshake interfaces for the postorder relabel unit: input items,
// result items and the configuration write channel. No dependencies.
interface tpr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [10:0] entry_index;
    logic [10:0] parent_node;
    logic [9:0]  postorder_position;
    logic [10:0] child_pointer;
    logic [9:0]  child_node;
    logic [1:0]  read_table;

    modport source (output valid, req_type, entry_index, parent_node,
                    postorder_position, child_pointer, child_node, read_table,
                    input ready);
    modport sink (input valid, req_type, entry_index, parent_node,
                  postorder_position, child_pointer, child_node, read_table,
                  output ready);
endinterface

interface tpr_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [10:0] out_value;

    modport source (output valid, out_kind, out_value, input ready);
    modport sink (input valid, out_kind, out_value, output ready);
endinterface

interface tpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] node_count;

    modport source (output valid, node_count, input ready);
    modport sink (input valid, node_count, output ready);
endinterface

@@ hdl/tpr_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write and one registered read port.
// No dependencies.
module tpr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered, data held between reads.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tpr_core.sv @@
`timescale 1ns / 1ps
// Sequencer and stores of the postorder relabel unit.
// Depends on tpr_pkg and tpr_ram.
module tpr_core #(
    parameter int MAX_NODES = tpr_pkg::MAX_NODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [10:0]   i_node_count,
    input  logic          i_req_fire,
    input  tpr_pkg::t_req i_req,
    input  logic          i_res_free,
    output logic          o_idle,
    output tpr_pkg::t_res o_res
);

    localparam int AWN = $clog2(MAX_NODES);
    localparam int AWP = $clog2(MAX_NODES + 2);

    // Store ports.
    logic           we_par, re_par;
    logic [AWN-1:0] wa_par, ra_par;
    logic [10:0]    wd_par, rd_par;
    logic           we_pos, re_pos;
    logic [AWN-1:0] wa_pos, ra_pos;
    logic [9:0]     wd_pos, rd_pos;
    logic           we_cp, re_cp;
    logic [AWP-1:0] wa_cp, ra_cp;
    logic [10:0]    wd_cp, rd_cp;
    logic           we_ch, re_ch;
    logic [AWN-1:0] wa_ch, ra_ch;
    logic [9:0]     wd_ch, rd_ch;
    logic           we_np, re_np;
    logic [AWN-1:0] wa_np, ra_np;
    logic [10:0]    wd_np, rd_np;
    logic           we_nq, re_nq;
    logic [AWP-1:0] wa_nq, ra_nq;
    logic [10:0]    wd_nq, rd_nq;
    logic           we_nc, re_nc;
    logic [AWN-1:0] wa_nc, ra_nc;
    logic [9:0]     wd_nc, rd_nc;

    // Sequencer registers.
    tpr_pkg::t_state r_state, n_state;
    logic [11:0] r_i, n_i;
    logic [10:0] r_sum, n_sum;
    logic [10:0] r_pi, n_pi;
    logic [10:0] r_b, n_b;
    logic [10:0] r_e, n_e;
    logic [11:0] r_o, n_o;
    logic        r_parhi, n_parhi;
    logic        r_last, n_last;
    logic [9:0]  r_ch, n_ch;
    logic [1:0]  r_tbl, n_tbl;
    logic        r_zero, n_zero;
    logic        r_kind, n_kind;
    logic [10:0] r_val, n_val;

    logic [10:0] w_cnt;
    logic [11:0] w_cnt1;
    logic [10:0] w_slot;
    logic [11:0] w_sum;

    // Effective node count, capped at the capacity.
    assign w_cnt  = (32'(i_node_count) > MAX_NODES) ? 11'(MAX_NODES) : i_node_count;
    assign w_cnt1 = {1'b0, w_cnt} + 12'd1;

    tpr_ram #(.DEPTH(MAX_NODES), .WIDTH(11)) u_par (
        .i_clk(i_clk), .i_we(we_par), .i_waddr(wa_par), .i_wdata(wd_par),
        .i_re(re_par), .i_raddr(ra_par), .o_rdata(rd_par));
    tpr_ram #(.DEPTH(MAX_NODES), .WIDTH(10)) u_pos (
        .i_clk(i_clk), .i_we(we_pos), .i_waddr(wa_pos), .i_wdata(wd_pos),
        .i_re(re_pos), .i_raddr(ra_pos), .o_rdata(rd_pos));
    tpr_ram #(.DEPTH(MAX_NODES + 2), .WIDTH(11)) u_cp (
        .i_clk(i_clk), .i_we(we_cp), .i_waddr(wa_cp), .i_wdata(wd_cp),
        .i_re(re_cp), .i_raddr(ra_cp), .o_rdata(rd_cp));
    tpr_ram #(.DEPTH(MAX_NODES), .WIDTH(10)) u_ch (
        .i_clk(i_clk), .i_we(we_ch), .i_waddr(wa_ch), .i_wdata(wd_ch),
        .i_re(re_ch), .i_raddr(ra_ch), .o_rdata(rd_ch));
    tpr_ram #(.DEPTH(MAX_NODES), .WIDTH(11)) u_np (
        .i_clk(i_clk), .i_we(we_np), .i_waddr(wa_np), .i_wdata(wd_np),
        .i_re(re_np), .i_raddr(ra_np), .o_rdata(rd_np));
    tpr_ram #(.DEPTH(MAX_NODES + 2), .WIDTH(11)) u_nq (
        .i_clk(i_clk), .i_we(we_nq), .i_waddr(wa_nq), .i_wdata(wd_nq),
        .i_re(re_nq), .i_raddr(ra_nq), .o_rdata(rd_nq));
    tpr_ram #(.DEPTH(MAX_NODES), .WIDTH(10)) u_nc (
        .i_clk(i_clk), .i_we(we_nc), .i_waddr(wa_nc), .i_wdata(wd_nc),
        .i_re(re_nc), .i_raddr(ra_nc), .o_rdata(rd_nc));

    // Control state clears on reset; the datapath registers need none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_sum   <= n_sum;
        r_pi    <= n_pi;
        r_b     <= n_b;
        r_e     <= n_e;
        r_o     <= n_o;
        r_parhi <= n_parhi;
        r_last  <= n_last;
        r_ch    <= n_ch;
        r_tbl   <= n_tbl;
        r_zero  <= n_zero;
        r_kind  <= n_kind;
        r_val   <= n_val;
    end

    // Next state, store accesses and result push.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_sum   = r_sum;
        n_pi    = r_pi;
        n_b     = r_b;
        n_e     = r_e;
        n_o     = r_o;
        n_parhi = r_parhi;
        n_last  = r_last;
        n_ch    = r_ch;
        n_tbl   = r_tbl;
        n_zero  = r_zero;
        n_kind  = r_kind;
        n_val   = r_val;
        w_slot  = '0;
        w_sum   = '0;
        o_res   = '0;
        we_par = 1'b0; wa_par = '0; wd_par = '0; re_par = 1'b0; ra_par = '0;
        we_pos = 1'b0; wa_pos = '0; wd_pos = '0; re_pos = 1'b0; ra_pos = '0;
        we_cp  = 1'b0; wa_cp  = '0; wd_cp  = '0; re_cp  = 1'b0; ra_cp  = '0;
        we_ch  = 1'b0; wa_ch  = '0; wd_ch  = '0; re_ch  = 1'b0; ra_ch  = '0;
        we_np  = 1'b0; wa_np  = '0; wd_np  = '0; re_np  = 1'b0; ra_np  = '0;
        we_nq  = 1'b0; wa_nq  = '0; wd_nq  = '0; re_nq  = 1'b0; ra_nq  = '0;
        we_nc  = 1'b0; wa_nc  = '0; wd_nc  = '0; re_nc  = 1'b0; ra_nc  = '0;

        unique case (r_state)
            tpr_pkg::ST_IDLE: begin
                if (i_req_fire) begin
                    unique case (i_req.req_type)
                        tpr_pkg::REQ_LOAD_NODE: begin
                            if (32'(i_req.entry_index) < MAX_NODES) begin
                                we_par = 1'b1;
                                wa_par = AWN'(i_req.entry_index);
                                wd_par = i_req.parent_node;
                                we_pos = 1'b1;
                                wa_pos = AWN'(i_req.entry_index);
                                wd_pos = i_req.postorder_position;
                            end
                            if (32'(i_req.entry_index) < MAX_NODES + 2) begin
                                we_cp = 1'b1;
                                wa_cp = AWP'(i_req.entry_index);
                                wd_cp = i_req.child_pointer;
                            end
                        end
                        tpr_pkg::REQ_LOAD_CHILD: begin
                            if (32'(i_req.entry_index) < MAX_NODES) begin
                                we_ch = 1'b1;
                                wa_ch = AWN'(i_req.entry_index);
                                wd_ch = i_req.child_node;
                            end
                        end
                        tpr_pkg::REQ_COMPUTE: begin
                            n_i     = '0;
                            n_state = tpr_pkg::ST_CLR;
                        end
                        tpr_pkg::REQ_READ: begin
                            n_tbl   = i_req.read_table;
                            n_zero  = 1'b1;
                            n_state = tpr_pkg::ST_READ;
                            unique case (i_req.read_table)
                                tpr_pkg::TBL_PARENT: begin
                                    if (32'(i_req.entry_index) < MAX_NODES) begin
                                        n_zero = 1'b0;
                                        re_np  = 1'b1;
                                        ra_np  = AWN'(i_req.entry_index);
                                    end
                                end
                                tpr_pkg::TBL_POINTER: begin
                                    if (32'(i_req.entry_index) < MAX_NODES + 2) begin
                                        n_zero = 1'b0;
                                        re_nq  = 1'b1;
                                        ra_nq  = AWP'(i_req.entry_index);
                                    end
                                end
                                tpr_pkg::TBL_CHILD: begin
                                    if (32'(i_req.entry_index) < MAX_NODES) begin
                                        n_zero = 1'b0;
                                        re_nc  = 1'b1;
                                        ra_nc  = AWN'(i_req.entry_index);
                                    end
                                end
                                default: begin
                                    n_zero = 1'b1;
                                end
                            endcase
                        end
                        default: begin
                            n_state = tpr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Read data arrives; pick the table.
            tpr_pkg::ST_READ: begin
                n_kind = tpr_pkg::KIND_DATA;
                if (r_zero) begin
                    n_val = '0;
                end else if (r_tbl == tpr_pkg::TBL_PARENT) begin
                    n_val = rd_np;
                end else if (r_tbl == tpr_pkg::TBL_POINTER) begin
                    n_val = rd_nq;
                end else begin
                    n_val = {1'b0, rd_nc};
                end
                n_state = tpr_pkg::ST_EMIT;
            end

            // Hand the result to the output register once it has room.
            tpr_pkg::ST_EMIT: begin
                if (i_res_free) begin
                    o_res.valid     = 1'b1;
                    o_res.out_kind  = r_kind;
                    o_res.out_value = r_val;
                    n_state         = tpr_pkg::ST_IDLE;
                end
            end

            // Clear pointer entries 0 to count+1.
            tpr_pkg::ST_CLR: begin
                we_nq = 1'b1;
                wa_nq = AWP'(r_i);
                wd_nq = '0;
                if (r_i == w_cnt1) begin
                    n_i     = '0;
                    n_state = tpr_pkg::ST_P2A;
                end else begin
                    n_i = r_i + 12'd1;
                end
            end

            // Parent and count pass: fetch node record.
            tpr_pkg::ST_P2A: begin
                if (r_i < {1'b0, w_cnt}) begin
                    re_pos = 1'b1;
                    ra_pos = AWN'(r_i);
                    re_par = 1'b1;
                    ra_par = AWN'(r_i);
                end
                re_cp   = 1'b1;
                ra_cp   = AWP'(r_i);
                n_state = tpr_pkg::ST_P2B;
            end

            // Fetch list end and the parent's position.
            tpr_pkg::ST_P2B: begin
                n_last  = (r_i == {1'b0, w_cnt});
                n_pi    = n_last ? w_cnt : {1'b0, rd_pos};
                n_b     = rd_cp;
                n_parhi = (rd_par >= w_cnt);
                re_cp   = 1'b1;
                ra_cp   = AWP'(r_i + 12'd1);
                if (!n_last && !n_parhi) begin
                    re_pos = 1'b1;
                    ra_pos = AWN'(rd_par);
                end
                n_state = tpr_pkg::ST_P2C;
            end

            // Write the new parent and the child count at the new slot.
            tpr_pkg::ST_P2C: begin
                if (!r_last && 32'(r_pi) < MAX_NODES) begin
                    we_np = 1'b1;
                    wa_np = AWN'(r_pi);
                    wd_np = r_parhi ? w_cnt : {1'b0, rd_pos};
                end
                if (32'(r_pi) < MAX_NODES + 2) begin
                    we_nq = 1'b1;
                    wa_nq = AWP'(r_pi);
                    wd_nq = (rd_cp > r_b) ? (rd_cp - r_b) : 11'd0;
                end
                if (r_last) begin
                    n_i     = '0;
                    n_sum   = '0;
                    n_state = tpr_pkg::ST_SUMR;
                end else begin
                    n_i     = r_i + 12'd1;
                    n_state = tpr_pkg::ST_P2A;
                end
            end

            // Exclusive prefix sum over the counts, saturating.
            tpr_pkg::ST_SUMR: begin
                re_nq   = 1'b1;
                ra_nq   = AWP'(r_i);
                n_state = tpr_pkg::ST_SUMW;
            end

            tpr_pkg::ST_SUMW: begin
                we_nq = 1'b1;
                wa_nq = AWP'(r_i);
                wd_nq = r_sum;
                w_sum = {1'b0, r_sum} + {1'b0, rd_nq};
                n_sum = (w_sum > {1'b0, tpr_pkg::PTR_MAX}) ? tpr_pkg::PTR_MAX : w_sum[10:0];
                if (r_i == w_cnt1) begin
                    n_i     = '0;
                    n_state = tpr_pkg::ST_P3A;
                end else begin
                    n_i     = r_i + 12'd1;
                    n_state = tpr_pkg::ST_SUMR;
                end
            end

            // Scatter pass: fetch slot and list start.
            tpr_pkg::ST_P3A: begin
                if (r_i < {1'b0, w_cnt}) begin
                    re_pos = 1'b1;
                    ra_pos = AWN'(r_i);
                end
                re_cp   = 1'b1;
                ra_cp   = AWP'(r_i);
                n_state = tpr_pkg::ST_P3B;
            end

            // Fetch list end and the new list start.
            tpr_pkg::ST_P3B: begin
                n_last = (r_i == {1'b0, w_cnt});
                w_slot = n_last ? w_cnt : {1'b0, rd_pos};
                n_pi   = w_slot;
                n_b    = rd_cp;
                re_cp  = 1'b1;
                ra_cp  = AWP'(r_i + 12'd1);
                if (32'(w_slot) < MAX_NODES + 2) begin
                    re_nq = 1'b1;
                    ra_nq = AWP'(w_slot);
                end
                n_state = tpr_pkg::ST_P3C;
            end

            tpr_pkg::ST_P3C: begin
                n_e = rd_cp;
                n_o = {1'b0, rd_nq};
                if (32'(r_pi) < MAX_NODES + 2) begin
                    n_state = tpr_pkg::ST_LA;
                end else if (r_last) begin
                    n_kind  = tpr_pkg::KIND_DONE;
                    n_val   = '0;
                    n_state = tpr_pkg::ST_EMIT;
                end else begin
                    n_i     = r_i + 12'd1;
                    n_state = tpr_pkg::ST_P3A;
                end
            end

            // One child per round: fetch child, fetch its position, write.
            tpr_pkg::ST_LA: begin
                if (r_b < r_e && 32'(r_b) < MAX_NODES && 32'(r_o) < MAX_NODES) begin
                    re_ch   = 1'b1;
                    ra_ch   = AWN'(r_b);
                    n_state = tpr_pkg::ST_LB;
                end else if (r_last) begin
                    n_kind  = tpr_pkg::KIND_DONE;
                    n_val   = '0;
                    n_state = tpr_pkg::ST_EMIT;
                end else begin
                    n_i     = r_i + 12'd1;
                    n_state = tpr_pkg::ST_P3A;
                end
            end

            tpr_pkg::ST_LB: begin
                n_ch = rd_ch;
                if (32'(rd_ch) < MAX_NODES) begin
                    re_pos = 1'b1;
                    ra_pos = AWN'(rd_ch);
                end
                n_state = tpr_pkg::ST_LC;
            end

            tpr_pkg::ST_LC: begin
                we_nc   = 1'b1;
                wa_nc   = AWN'(r_o);
                wd_nc   = (32'(r_ch) < MAX_NODES) ? rd_pos : 10'd0;
                n_b     = r_b + 11'd1;
                n_o     = r_o + 12'd1;
                n_state = tpr_pkg::ST_LA;
            end

            default: begin
                n_state = tpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == tpr_pkg::ST_IDLE);

endmodule

@@ hdl/tree_postorder_relabel_unit.sv @@
`timescale 1ns / 1ps
// Postorder relabel unit: node count register, result register, core.
// Load items are written while idle. A read's result passes the store's read
// register, ST_READ, ST_EMIT and the output register; output stalls hold it in
// ST_EMIT, and the next item is taken once back in idle. Compute runs the clear,
// parent and count, prefix sum and scatter passes; one item is worked at a time.
// Reset clears the node count and control; the stores are not cleared.
// Depends on tpr_pkg, tpr_if, tpr_ram and tpr_core.
module tree_postorder_relabel_unit #(
    parameter int MAX_NODES = tpr_pkg::MAX_NODES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tpr_in_if.sink   i_item,
    tpr_out_if.source o_result,
    tpr_cfg_if.sink  i_cfg
);

    logic [10:0]   r_node_count;
    logic          r_out_valid;
    logic          r_out_kind;
    logic [10:0]   r_out_value;
    logic          w_idle;
    logic          w_fire;
    logic          w_res_free;
    tpr_pkg::t_req w_req;
    tpr_pkg::t_res w_res;

    // Configuration is always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg.valid) begin
            r_node_count <= i_cfg.node_count;
        end
    end

    // Input item handshake and payload bundle.
    assign i_item.ready = w_idle;
    assign w_fire       = i_item.valid && w_idle;

    always_comb begin
        w_req.req_type           = i_item.req_type;
        w_req.entry_index        = i_item.entry_index;
        w_req.parent_node        = i_item.parent_node;
        w_req.postorder_position = i_item.postorder_position;
        w_req.child_pointer      = i_item.child_pointer;
        w_req.child_node         = i_item.child_node;
        w_req.read_table         = i_item.read_table;
    end

    tpr_core #(.MAX_NODES(MAX_NODES)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_req_fire   (w_fire),
        .i_req        (w_req),
        .i_res_free   (w_res_free),
        .o_idle       (w_idle),
        .o_res        (w_res)
    );

    // Output register holds a result until it is taken.
    assign w_res_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_kind  <= w_res.out_kind;
            r_out_value <= w_res.out_value;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.out_kind  = r_out_kind;
    assign o_result.out_value = r_out_value;

    // A result is pushed only when the output register has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (!r_out_valid || o_result.ready))
        else $error("result pushed into a full output register");

    // A load item produces no result and leaves the block ready.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_item.req_type == tpr_pkg::REQ_LOAD_NODE ||
                    i_item.req_type == tpr_pkg::REQ_LOAD_CHILD))
        |=> (w_idle && !w_res.valid))
        else $error("load item disturbed the sequencer");

    // A compute item never answers in the next cycle.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_item.req_type == tpr_pkg::REQ_COMPUTE) |=> (!w_idle && !w_res.valid))
        else $error("compute finished too early");

endmodule
